// ===== hdl/bounded_list_deque_search_sort_defines.svh =====
// Assertion helpers for the RTL controller
`ifndef BOUNDED_LIST_DEQUE_SEARCH_SORT_DEFINES_SVH
`define BOUNDED_LIST_DEQUE_SEARCH_SORT_DEFINES_SVH
// implication checked on every clock, off during reset
`define BL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define BL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/bldq_pkg.sv =====
package bldq_pkg;
    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned VAL_W = 32;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_DELETE     = 3'd2,
        OP_SEARCH     = 3'd3,
        OP_SORT       = 3'd4,
        OP_DISPLAY    = 3'd5,
        OP_RSVD6      = 3'd6,
        OP_RSVD7      = 3'd7
    } t_op;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // datapath commands
    typedef struct packed {
        logic [1:0] rd_sel;     // 0: i, 1: j, 2: m, 3: i - 1
        logic       wr_en;      // write wr_data_sel to wr_sel pointer
        logic [1:0] wr_sel;     // 0: i, 1: m, 2: len
        logic [1:0] wr_data_sel; // 0: value, 1: read data, 2: hold reg
        logic       hold_ld;    // capture read data into hold reg
        logic       best_ld;    // capture read data as best, m <= j
        logic       i_clr;
        logic       i_inc;
        logic       i_dec;
        logic       i_len;      // i <= len
        logic       i_lenm1;    // i <= len - 1
        logic       j_from_i;   // j <= i + 1
        logic       j_inc;
        logic       m_from_i;
        logic       m_lenm1;    // m <= len - 1
        logic       len_inc;
        logic       len_dec;
    } t_cmd;

    // datapath status
    typedef struct packed {
        logic       rd_eq_val;  // read data equals value
        logic       rd_lt_best; // read data below best (signed)
        logic       len_zero;
        logic       len_full;
        logic       i_last;     // i + 1 >= len
        logic       i_zero;
        logic       j_end;      // j >= len
        logic       m_eq_i;
    } t_sts;
endpackage

// ===== hdl/bounded_list_deque_search_sort.sv =====
// Push back writes one word; push front, delete, search, display and sort walk the
// list through the element RAM's registered read port.
// One item at a time; busy drops as the last result word appears, and the
// receiver cannot stall. Synchronous active-low reset empties the list;
// the store is not cleared.
module bounded_list_deque_search_sort #(
    parameter int unsigned DEPTH = bldq_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [4:0]         o_position,
    output logic [4:0]         o_count,
    output logic signed [31:0] o_element,
    output logic               o_last
);
    import bldq_pkg::*;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    t_cmd          w_cmd;
    t_sts          w_sts;
    logic          w_val_ld;
    logic [CW-1:0] w_len, w_i;
    logic [31:0]   w_rdata;

    bldq_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_val_ld(w_val_ld), .i_value(i_value),
        .i_cmd(w_cmd), .o_sts(w_sts), .o_len(w_len), .o_i(w_i), .o_rdata(w_rdata)
    );

    bldq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_op(i_op),
        .i_sts(w_sts), .i_len(w_len), .i_i(w_i), .i_rdata(w_rdata),
        .o_val_ld(w_val_ld), .o_cmd(w_cmd), .o_busy(busy), .o_valid(o_valid),
        .o_status(o_status), .o_position(o_position), .o_count(o_count),
        .o_element(o_element), .o_last(o_last)
    );
endmodule

// ===== hdl/bldq_ram.sv =====
module bldq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== hdl/bldq_dp.sv =====
module bldq_dp #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_val_ld,
    input  logic signed [31:0]           i_value,
    input  bldq_pkg::t_cmd               i_cmd,
    output bldq_pkg::t_sts               o_sts,
    output logic [$clog2(DEPTH+1)-1:0]   o_len,
    output logic [$clog2(DEPTH+1)-1:0]   o_i,
    output logic [31:0]                  o_rdata
);
    import bldq_pkg::*;
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_len, r_i, r_j, r_m;
    logic [31:0]   r_val, r_hold, r_best;
    logic [CW-1:0] w_raddr, w_waddr;
    logic [31:0]   w_wdata, w_rdata;

    // read address, write address and write data select
    always_comb begin
        unique case (i_cmd.rd_sel)
            2'd0:    w_raddr = r_i;
            2'd1:    w_raddr = r_j;
            2'd2:    w_raddr = r_m;
            default: w_raddr = r_i - CW'(1);
        endcase
        unique case (i_cmd.wr_sel)
            2'd0:    w_waddr = r_i;
            2'd1:    w_waddr = r_m;
            default: w_waddr = r_len;
        endcase
        unique case (i_cmd.wr_data_sel)
            2'd0:    w_wdata = r_val;
            2'd1:    w_wdata = w_rdata;
            default: w_wdata = r_hold;
        endcase
    end

    bldq_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (w_waddr[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // pointers and length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.len_inc) begin
            r_len <= r_len + CW'(1);
        end else if (i_cmd.len_dec) begin
            r_len <= r_len - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_val_ld) r_val <= i_value;
        if (i_cmd.hold_ld) r_hold <= w_rdata;
        if (i_cmd.i_clr) r_i <= '0;
        else if (i_cmd.i_inc) r_i <= r_i + CW'(1);
        else if (i_cmd.i_dec) r_i <= r_i - CW'(1);
        else if (i_cmd.i_len) r_i <= r_len;
        else if (i_cmd.i_lenm1) r_i <= r_len - CW'(1);
        if (i_cmd.j_from_i) r_j <= r_i + CW'(1);
        else if (i_cmd.j_inc) r_j <= r_j + CW'(1);
        if (i_cmd.m_from_i) r_m <= r_i;
        else if (i_cmd.best_ld) r_m <= r_j;
        else if (i_cmd.m_lenm1) r_m <= r_len - CW'(1);
        if (i_cmd.best_ld) r_best <= w_rdata;
    end

    // status to the controller
    always_comb begin
        o_sts.rd_eq_val  = (w_rdata == r_val);
        o_sts.rd_lt_best = ($signed(w_rdata) < $signed(r_best));
        o_sts.len_zero   = (r_len == '0);
        o_sts.len_full   = (r_len >= CW'(DEPTH));
        o_sts.i_last     = ((r_i + CW'(1)) >= r_len);
        o_sts.i_zero     = (r_i == '0);
        o_sts.j_end      = (r_j >= r_len);
        o_sts.m_eq_i     = (r_m == r_i);
    end
    assign o_len   = r_len;
    assign o_i     = r_i;
    assign o_rdata = w_rdata;
endmodule

// ===== hdl/bldq_ctrl.sv =====
`include "bounded_list_deque_search_sort_defines.svh"
module bldq_ctrl #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [2:0]                 i_op,
    input  bldq_pkg::t_sts             i_sts,
    input  logic [$clog2(DEPTH+1)-1:0] i_len,
    input  logic [$clog2(DEPTH+1)-1:0] i_i,
    input  logic [31:0]                i_rdata,
    output logic                       o_val_ld,
    output bldq_pkg::t_cmd             o_cmd,
    output logic                       o_busy,
    output logic                       o_valid,
    output logic [1:0]                 o_status,
    output logic [4:0]                 o_position,
    output logic [4:0]                 o_count,
    output logic signed [31:0]         o_element,
    output logic                       o_last
);
    import bldq_pkg::*;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_PF_RD, S_PF_WR, S_PF_INS,
        S_DEL_RD0, S_DEL_CK0, S_DEL_CKT, S_DEL_RDI, S_DEL_CKI,
        S_SH_RD, S_SH_WR,
        S_SR_RD, S_SR_CK,
        S_SO_RDI, S_SO_CKI, S_SO_RDJ, S_SO_CKJ, S_SO_RDM, S_SO_SW1, S_SO_SW2,
        S_DI_RD, S_DI_OUT,
        S_DONE
    } t_state;

    t_state        r_state;
    t_op           r_op;
    logic [1:0]    r_status;
    logic [4:0]    r_pos;
    t_cmd          w_cmd;

    // registered result port
    logic       r_valid, r_last, r_busy;
    logic [1:0] r_ostat;
    logic [4:0] r_opos, r_ocnt;
    logic [31:0] r_oelem;

    always_comb begin
        w_cmd = '0;
        unique case (r_state)
            S_PF_RD: begin
                w_cmd.rd_sel = 2'd3;  // read i - 1
            end
            S_PF_WR: begin
                w_cmd.wr_en = 1'b1; w_cmd.wr_sel = 2'd0; w_cmd.wr_data_sel = 2'd1;
                w_cmd.i_dec = 1'b1;
            end
            S_PF_INS: begin
                w_cmd.wr_en = 1'b1; w_cmd.wr_sel = 2'd0; w_cmd.len_inc = 1'b1;
            end
            S_DEL_RD0: begin
                w_cmd.rd_sel = 2'd0;
            end
            S_DEL_CK0: begin
                w_cmd.rd_sel = 2'd2;  // m holds len - 1
            end
            S_DEL_RDI, S_SR_RD, S_SO_RDI, S_DI_RD: begin
                w_cmd.rd_sel = 2'd0;
            end
            S_SH_RD, S_SO_RDJ: begin
                w_cmd.rd_sel = 2'd1;
            end
            S_SH_WR: begin
                w_cmd.wr_en = 1'b1; w_cmd.wr_sel = 2'd0; w_cmd.wr_data_sel = 2'd1;
                w_cmd.i_inc = 1'b1;
            end
            S_SO_RDM: begin
                w_cmd.rd_sel = 2'd0;
            end
            S_SO_SW1: begin
                // word at i goes to m while the old word at m is read
                w_cmd.hold_ld = 1'b1; w_cmd.rd_sel = 2'd2;
                w_cmd.wr_en = 1'b1; w_cmd.wr_sel = 2'd1; w_cmd.wr_data_sel = 2'd1;
            end
            S_SO_SW2: begin
                w_cmd.wr_en = 1'b1; w_cmd.wr_sel = 2'd0; w_cmd.wr_data_sel = 2'd1;
            end
            default: ;
        endcase
    end

    // sequencer; the extra pointer moves per state are in the block below
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op     <= t_op'(i_op);
                        r_busy   <= 1'b1;
                        r_status <= ST_OK;
                        r_pos    <= '0;
                        r_state  <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    priority if ((r_op == OP_PUSH_FRONT || r_op == OP_PUSH_BACK)
                                 && i_sts.len_full) begin
                        r_status <= ST_FULL;
                        r_state  <= S_DONE;
                    end else if ((r_op == OP_DELETE || r_op == OP_SEARCH ||
                                  r_op == OP_SORT || r_op == OP_DISPLAY)
                                 && i_sts.len_zero) begin
                        r_status <= ST_EMPTY;
                        r_state  <= S_DONE;
                    end else begin
                        unique case (r_op)
                            OP_PUSH_FRONT: r_state <= i_sts.len_zero ? S_PF_INS : S_PF_RD;
                            OP_PUSH_BACK:  r_state <= S_PF_INS;
                            OP_DELETE:     r_state <= S_DEL_RD0;
                            OP_SEARCH:     r_state <= S_SR_RD;
                            OP_SORT:       r_state <= S_SO_RDI;
                            OP_DISPLAY:    r_state <= S_DI_RD;
                            default:       r_state <= S_DONE;
                        endcase
                    end
                end
                S_PF_RD:   r_state <= S_PF_WR;
                S_PF_WR:   r_state <= (i_i == CW'(1)) ? S_PF_INS : S_PF_RD;
                S_PF_INS:  r_state <= S_DONE;
                S_DEL_RD0: r_state <= S_DEL_CK0;
                S_DEL_CK0: r_state <= i_sts.rd_eq_val ? S_SH_RD : S_DEL_CKT;
                S_DEL_CKT: begin
                    if (i_sts.rd_eq_val) begin
                        r_state <= S_DONE;
                    end else if (i_sts.i_last) begin
                        r_status <= ST_NOTFOUND;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_DEL_RDI;
                    end
                end
                S_DEL_RDI: r_state <= S_DEL_CKI;
                S_DEL_CKI: begin
                    priority if (i_sts.rd_eq_val) r_state <= S_SH_RD;
                    else if (i_sts.i_last) begin
                        r_status <= ST_NOTFOUND;
                        r_state  <= S_DONE;
                    end else r_state <= S_DEL_RDI;
                end
                S_SH_RD: r_state <= i_sts.j_end ? S_DONE : S_SH_WR;
                S_SH_WR: r_state <= S_SH_RD;
                S_SR_RD: r_state <= S_SR_CK;
                S_SR_CK: begin
                    priority if (i_sts.rd_eq_val) begin
                        r_pos   <= 5'(i_i + CW'(1));
                        r_state <= S_DONE;
                    end else if (i_sts.i_last) begin
                        r_status <= ST_NOTFOUND;
                        r_state  <= S_DONE;
                    end else r_state <= S_SR_RD;
                end
                S_SO_RDI: r_state <= i_sts.i_last ? S_DONE : S_SO_CKI;
                S_SO_CKI: r_state <= S_SO_RDJ;
                S_SO_RDJ: r_state <= S_SO_CKJ;
                S_SO_CKJ: r_state <= i_sts.j_end ? S_SO_RDM : S_SO_RDJ;
                S_SO_RDM: r_state <= i_sts.m_eq_i ? S_SO_RDI : S_SO_SW1;
                S_SO_SW1: r_state <= S_SO_SW2;
                S_SO_SW2: r_state <= S_SO_RDI;
                S_DI_RD:  r_state <= S_DI_OUT;
                S_DI_OUT: begin
                    r_valid <= 1'b1;
                    r_ostat <= ST_OK;
                    r_opos  <= '0;
                    r_ocnt  <= 5'(i_len);
                    r_oelem <= i_rdata;
                    r_last  <= i_sts.i_last;
                    if (i_sts.i_last) begin
                        r_busy  <= 1'b0;
                        r_state <= S_IDLE;
                    end else r_state <= S_DI_RD;
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_ostat <= r_status;
                    r_opos  <= r_pos;
                    r_ocnt  <= 5'(i_len);
                    r_oelem <= '0;
                    r_last  <= 1'b1;
                    r_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // pointer commands depending on state and status
    always_comb begin
        o_cmd = w_cmd;
        o_val_ld = (r_state == S_IDLE) && i_start;
        unique case (r_state)
            S_DISPATCH: begin
                if (r_op == OP_PUSH_FRONT) begin
                    o_cmd.i_len = 1'b1;
                    if (i_sts.len_zero) o_cmd.i_clr = 1'b1;
                end
                if (r_op == OP_PUSH_BACK) o_cmd.i_len = 1'b1;
                if (r_op == OP_DELETE || r_op == OP_SEARCH || r_op == OP_SORT ||
                    r_op == OP_DISPLAY) o_cmd.i_clr = 1'b1;
            end
            default: ;
        endcase
        // head check sets up the tail read through m; interior scan starts at one
        unique case (r_state)
            S_PF_WR: begin
                o_cmd.j_inc = 1'b0;
            end
            S_DEL_RD0: begin
                o_cmd.m_lenm1 = 1'b1;
            end
            S_DEL_CK0: begin
                if (i_sts.rd_eq_val) o_cmd.j_from_i = 1'b1;
                else o_cmd.i_inc = 1'b1;
            end
            S_DEL_CKT: begin
                if (i_sts.rd_eq_val) o_cmd.len_dec = 1'b1;
            end
            S_DEL_CKI: begin
                if (i_sts.rd_eq_val) o_cmd.j_from_i = 1'b1;
                else o_cmd.i_inc = 1'b1;
            end
            S_SH_RD: begin
                if (i_sts.j_end) o_cmd.len_dec = 1'b1;
                else o_cmd.j_inc = 1'b1;
            end
            S_SR_CK: o_cmd.i_inc = !i_sts.rd_eq_val;
            S_SO_RDI: begin
                o_cmd.j_from_i = 1'b1;
                o_cmd.m_from_i = 1'b1;
            end
            S_SO_CKI: begin
                o_cmd.best_ld = 1'b1;
                o_cmd.m_from_i = 1'b1;
            end
            S_SO_CKJ: begin
                // the read past the end is dropped
                if (!i_sts.j_end && i_sts.rd_lt_best) o_cmd.best_ld = 1'b1;
                if (!i_sts.j_end) o_cmd.j_inc = 1'b1;
            end
            S_SO_RDM: if (i_sts.m_eq_i) o_cmd.i_inc = 1'b1;
            S_SO_SW2: begin
                o_cmd.i_inc = 1'b1;
            end
            S_DI_OUT: o_cmd.i_inc = 1'b1;
            default: ;
        endcase
    end

    assign o_busy     = r_busy;
    assign o_valid    = r_valid;
    assign o_status   = r_ostat;
    assign o_position = r_opos;
    assign o_count    = r_ocnt;
    assign o_element  = r_oelem;
    assign o_last     = r_last;

    `BL_ASSERT_IMP(a_last_ends, i_clk, i_rst_n, r_valid && r_last, !r_busy)
    `BL_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !r_busy, r_busy)
    `BL_ASSERT_IMP(a_idle_free, i_clk, i_rst_n, r_state == S_IDLE, !r_busy)
endmodule
